>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the text console writer. The clocked checks are
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk, outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds, outside of reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, constants and helpers for the text console writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS       = 80;
  localparam int ROWS          = 25;
  localparam int CELLS         = ROWS * COLUMNS;
  localparam int LAST_ROW_BASE = CELLS - COLUMNS;
  localparam int POS_W         = $clog2(CELLS);
  localparam int ROW_W         = $clog2(ROWS);
  localparam int COL_W         = $clog2(COLUMNS);

  // Field widths
  localparam int OP_W     = 2;
  localparam int BYTE_W   = 8;
  localparam int ADDR_W   = 11;
  localparam int CURSOR_W = 11;
  localparam int CELL_W   = 16;

  // Request queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Bytes and cell values
  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;
  localparam logic [BYTE_W-1:0] BLANK_GLYPH  = 8'h20;
  localparam logic [BYTE_W-1:0] COLOR_RESET  = 8'h07;
  localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0720;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] character;
    logic [ADDR_W-1:0] cell_address;
  } in_item_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_position;
    logic [CELL_W-1:0]   read_data;
    logic                scrolled;
  } out_item_t;

  // Classified request as it leaves the front
  typedef enum logic [2:0] {
    CMD_GLYPH,
    CMD_NEWLINE,
    CMD_CLEAR,
    CMD_READ,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [BYTE_W-1:0] glyph;
    logic [POS_W-1:0]  addr;
    logic              in_range;
  } cmd_t;

  // Back end sequencer
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ_WAIT,
    ST_SCROLL,
    ST_DRAIN,
    ST_FILL,
    ST_DONE
  } state_t;

  // Status from the back end
  typedef struct packed {
    logic init;
    logic load;
  } back_status_t;

  // Keep a screen position to the width of the cursor register
  function automatic logic [CURSOR_W-1:0] to_cursor(input logic [POS_W:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[CURSOR_W-1:0];
  endfunction

endpackage

>>> hdl/text_console_writer_unit.sv
// Flow: the back end sequencer, with its single write port, takes one request
// at a time; the front queue accepts more until it is full. Clear, and a put
// that scrolls, hold the queue for a full pass over the screen memory.
// Reset (rst, synchronous): screen memory is filled with 0x0720 in one pass,
// in_stall stays high until it ends; position, cursor and color (7) reset at once.
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text console top level: request queue front, execution back end, color
// register on its own write channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module text_console_writer_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tcw_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output tcw_pkg::out_item_t  out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);
  import tcw_pkg::*;

  logic         q_valid;
  cmd_t         q_cmd;
  logic         q_pop;
  logic [7:0]   color;
  back_status_t status;

  // Color register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      color <= COLOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      color <= cfg_data;
    end
  end

  tcw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .hold     (status.init),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  tcw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .color     (color),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .status    (status)
  );

  // Back end only takes a request that the queue holds
  `ASSERT_CLK(a_pop_nonempty, q_pop |-> q_valid, "pop from empty request queue")
  // A result is never loaded over one that is still stalled
  `ASSERT_NEVER(a_no_overwrite, status.load && out_valid && out_stall, "result overwritten")
  // A scrolling result leaves the cursor at the start of the bottom row
  `ASSERT_CLK(a_scroll_cursor,
              (out_valid && out_item.scrolled) |->
                (out_item.cursor_position == to_cursor((POS_W+1)'(LAST_ROW_BASE))),
              "cursor not at bottom row after scroll")
  // No request is taken during the clearing pass after reset
  `ASSERT_CLK(a_init_hold, status.init |-> (in_stall && !q_pop), "request taken during init")

endmodule

>>> hdl/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// Accepts input requests, classifies them and holds them in a short queue
// for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  tcw_pkg::in_item_t in_item,
  input  logic             hold,
  output logic             q_valid,
  output tcw_pkg::cmd_t    q_cmd,
  input  logic             q_pop
);
  import tcw_pkg::*;

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;
  cmd_t              cls;

  // Classify the incoming request
  always_comb begin
    cls.glyph    = in_item.character;
    cls.addr     = POS_W'(in_item.cell_address);
    cls.in_range = 32'(in_item.cell_address) < CELLS;
    unique case (in_item.operation)
      OP_PUT:   cls.kind = (in_item.character == NEWLINE_BYTE) ? CMD_NEWLINE : CMD_GLYPH;
      OP_CLEAR: cls.kind = CMD_CLEAR;
      OP_READ:  cls.kind = CMD_READ;
      default:  cls.kind = CMD_NOP;
    endcase
  end

  // Stall while full or while the back end clears memory after reset
  assign in_stall = (count == (QPTR_W+1)'(QDEPTH)) || hold;
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;
  assign q_valid  = count != '0;
  assign q_cmd    = entries[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cls;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// Carries out queued requests on the screen memory: cell writes, reads,
// scroll and clear passes, and holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            color,
  input  logic                  q_valid,
  input  tcw_pkg::cmd_t         q_cmd,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tcw_pkg::out_item_t    out_item,
  output tcw_pkg::back_status_t status
);
  import tcw_pkg::*;

  state_t state;
  state_t state_next;

  // Screen memory
  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rd_q;
  logic              we;
  logic [POS_W-1:0]  waddr;
  logic [CELL_W-1:0] wdata;
  logic              re;
  logic [POS_W-1:0]  raddr;

  // Write position and cursor
  logic [ROW_W-1:0]    row;
  logic [COL_W-1:0]    col;
  logic [POS_W-1:0]    pos;
  logic [CURSOR_W-1:0] cursor;

  // Sweep counter and scroll write stage
  logic [POS_W-1:0] idx;
  logic             pend_valid;
  logic [POS_W-1:0] pend_addr;
  logic             pend_blank;

  // Pending result; the cursor is taken from the cursor register at load
  logic                res_range;
  logic [CELL_W-1:0]   res_data;
  logic                res_scrolled;

  logic              load;
  logic              at_last_col;
  logic              at_last_row;
  logic              scroll_hit;
  logic              sweep_end;
  logic [POS_W:0]    pos_inc;
  logic [POS_W-1:0]  nl_pos;
  logic [POS_W:0]    src_sum;
  logic [CELL_W-1:0] blank_cell;

  // Position arithmetic
  assign at_last_col = col == COL_W'(COLUMNS - 1);
  assign at_last_row = row == ROW_W'(ROWS - 1);
  assign sweep_end   = idx == POS_W'(CELLS - 1);
  assign pos_inc     = {1'b0, pos} + 1'b1;
  assign nl_pos      = POS_W'({1'b0, pos} - (POS_W+1)'(col) + (POS_W+1)'(COLUMNS));
  assign src_sum     = {1'b0, idx} + (POS_W+1)'(COLUMNS);
  assign blank_cell  = {color, BLANK_GLYPH};

  // Request at the head of the queue moves the screen up
  assign scroll_hit  = ((q_cmd.kind == CMD_GLYPH) && at_last_col && at_last_row) ||
                       ((q_cmd.kind == CMD_NEWLINE) && at_last_row);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (sweep_end) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.kind)
            CMD_GLYPH:   state_next = (at_last_col && at_last_row) ? ST_SCROLL : ST_DONE;
            CMD_NEWLINE: state_next = at_last_row ? ST_SCROLL : ST_DONE;
            CMD_CLEAR:   state_next = ST_FILL;
            CMD_READ:    state_next = ST_READ_WAIT;
            default:     state_next = ST_DONE;
          endcase
        end
      end
      ST_READ_WAIT: state_next = ST_DONE;
      ST_SCROLL: begin
        if (sweep_end) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_DONE;
      ST_FILL: begin
        if (sweep_end) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory port and handshake controls
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = blank_cell;
    re    = 1'b0;
    raddr = q_cmd.addr;
    q_pop = 1'b0;
    load  = 1'b0;
    unique case (state)
      ST_INIT: begin
        we    = 1'b1;
        wdata = RESET_CELL;
      end
      ST_IDLE: begin
        q_pop = q_valid;
        if (q_valid && q_cmd.kind == CMD_GLYPH) begin
          we    = 1'b1;
          waddr = pos;
          wdata = {color, q_cmd.glyph};
        end
        re = q_valid && q_cmd.kind == CMD_READ;
      end
      ST_SCROLL, ST_DRAIN: begin
        we    = pend_valid;
        waddr = pend_addr;
        wdata = pend_blank ? blank_cell : rd_q;
        re    = (state == ST_SCROLL) && (32'(idx) < LAST_ROW_BASE);
        raddr = src_sum[POS_W-1:0];
      end
      ST_FILL: we = 1'b1;
      ST_DONE: load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  // Screen memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  // Sequencer and position state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      idx       <= '0;
      row       <= '0;
      col       <= '0;
      pos       <= '0;
      cursor    <= '0;
      out_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;

      // Sweep counter for init, fill and scroll passes
      if (state == ST_INIT || state == ST_FILL || state == ST_SCROLL) begin
        idx <= sweep_end ? '0 : idx + 1'b1;
      end

      // Scroll write stage
      if (state == ST_SCROLL) begin
        pend_valid <= 1'b1;
        pend_addr  <= idx;
        pend_blank <= 32'(idx) >= LAST_ROW_BASE;
      end else begin
        pend_valid <= 1'b0;
      end

      // Request handling
      if (state == ST_IDLE && q_valid) begin
        res_data     <= '0;
        res_scrolled <= scroll_hit;
        res_range    <= q_cmd.in_range;
        unique case (q_cmd.kind)
          CMD_GLYPH: begin
            if (at_last_col) begin
              col <= '0;
              if (at_last_row) begin
                pos    <= POS_W'(LAST_ROW_BASE);
                cursor <= to_cursor((POS_W+1)'(LAST_ROW_BASE));
                idx    <= '0;
              end else begin
                row    <= row + 1'b1;
                pos    <= pos_inc[POS_W-1:0];
                cursor <= to_cursor(pos_inc);
              end
            end else begin
              col    <= col + 1'b1;
              pos    <= pos_inc[POS_W-1:0];
              cursor <= to_cursor(pos_inc);
            end
          end
          CMD_NEWLINE: begin
            col <= '0;
            if (at_last_row) begin
              pos    <= POS_W'(LAST_ROW_BASE);
              cursor <= to_cursor((POS_W+1)'(LAST_ROW_BASE));
              idx    <= '0;
            end else begin
              row    <= row + 1'b1;
              pos    <= nl_pos;
              cursor <= to_cursor({1'b0, nl_pos});
            end
          end
          CMD_CLEAR: begin
            row <= '0;
            col <= '0;
            pos <= '0;
            idx <= '0;
          end
          default: ;
        endcase
      end

      // Read data arrives in the cycle after the request, in ST_READ_WAIT
      if (state == ST_READ_WAIT) begin
        res_data <= res_range ? rd_q : '0;
      end

      // Result register
      if (load) begin
        out_valid <= 1'b1;
        out_item  <= '{cursor_position: cursor, read_data: res_data,
                       scrolled: res_scrolled};
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.init = state == ST_INIT;
  assign status.load = load;

endmodule
